@@ hw/rtl/ghdq_pkg.sv @@
// package: shared types, codes and constants for the graph hop distance query block
`timescale 1ns / 1ps

package ghdq_pkg;

  // fixed field widths
  localparam int unsigned VertexW  = 5;
  localparam int unsigned VcountW  = 6;
  localparam int unsigned HopW     = 5;
  localparam int unsigned ActionW  = 2;

  // defaults and fixed sizes
  localparam int unsigned MaxVerticesDefault = 32;
  localparam int unsigned QueueDepth         = 2;
  localparam logic [VcountW-1:0] VcountReset = 6'd32;
  localparam logic [HopW-1:0]    HopMax      = 5'd31;

  // action codes of an input transaction
  typedef enum logic [ActionW-1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_QUERY = 2'd2
  } act_e;

  // classified command handed from front to engine
  typedef enum logic [1:0] {
    OP_ADD,
    OP_CLEAR,
    OP_QUERY,
    OP_MISS
  } op_e;

  // engine state
  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } st_e;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [VertexW-1:0] first_vertex;
    logic [VertexW-1:0] second_vertex;
  } ghdq_in_t;

  typedef struct packed {
    logic [HopW-1:0] hop_distance;
    logic            unreachable;
  } ghdq_out_t;

  typedef struct packed {
    op_e                op;
    logic [VertexW-1:0] src;
    logic [VertexW-1:0] dst;
  } ghdq_cmd_t;

  // queue status and head command handed from queue to engine
  typedef struct packed {
    logic      empty;
    ghdq_cmd_t cmd;
  } ghdq_qstat_t;

endpackage

@@ hw/rtl/ghdq_front.sv @@
// front: accepts input transactions and classifies them into engine commands
`timescale 1ns / 1ps

module ghdq_front import ghdq_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDefault,
  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1)
) (
  input  logic            start_i,
  input  logic            busy_i,
  input  ghdq_in_t        cmd_i,
  input  logic [CntW-1:0] n_use_i,
  output logic            push_o,
  output ghdq_cmd_t       cmd_o
);

  logic accept;
  logic src_in_use, dst_in_use;
  logic src_in_mat, dst_in_mat;

  assign accept     = start_i && !busy_i;
  assign src_in_mat = 32'(cmd_i.first_vertex) < MAX_VERTICES;
  assign dst_in_mat = 32'(cmd_i.second_vertex) < MAX_VERTICES;
  assign src_in_use = 32'(cmd_i.first_vertex) < 32'(n_use_i);
  assign dst_in_use = 32'(cmd_i.second_vertex) < 32'(n_use_i);

  always_comb begin
    push_o     = 1'b0;
    cmd_o.op   = OP_ADD;
    cmd_o.src  = cmd_i.first_vertex;
    cmd_o.dst  = cmd_i.second_vertex;
    unique case (cmd_i.action)
      ACT_ADD: begin
        cmd_o.op = OP_ADD;
        push_o   = accept && src_in_mat && dst_in_mat;
      end
      ACT_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        push_o   = accept;
      end
      ACT_QUERY: begin
        cmd_o.op = (src_in_use && dst_in_use) ? OP_QUERY : OP_MISS;
        push_o   = accept;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/ghdq_fifo.sv @@
// command queue between front and engine
`timescale 1ns / 1ps

module ghdq_fifo import ghdq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ghdq_cmd_t   wdata_i,
  input  logic        pop_i,
  output logic        full_o,
  output ghdq_qstat_t stat_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  ghdq_cmd_t       mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = cnt_q == CntW'(QueueDepth);
  assign stat_o.empty = cnt_q == '0;
  assign stat_o.cmd   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ hw/rtl/ghdq_engine.sv @@
// engine: adjacency matrix and level-by-level frontier walk
`timescale 1ns / 1ps

module ghdq_engine import ghdq_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDefault,
  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1),
  localparam int unsigned IdxW = $clog2(MAX_VERTICES)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CntW-1:0] n_use_i,
  input  ghdq_qstat_t     q_i,
  output logic            pop_o,
  output logic            walking_o,
  output logic            res_valid_o,
  output ghdq_out_t       res_o
);

  logic [MAX_VERTICES-1:0] adj_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] frontier_q, frontier_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [MAX_VERTICES-1:0] use_mask, reach, next_set;
  logic [HopW-1:0]         level_q, level_d;
  logic [IdxW-1:0]         tgt_q, tgt_d;
  logic [IdxW-1:0]         src_idx, dst_idx;
  st_e                     st_q, st_d;
  logic                    hit, dead;
  logic                    do_add, do_clear, do_start;

  assign src_idx   = IdxW'(q_i.cmd.src);
  assign dst_idx   = IdxW'(q_i.cmd.dst);
  assign hit       = frontier_q[tgt_q];
  assign dead      = frontier_q == '0;
  assign walking_o = st_q == ST_WALK;
  assign do_add    = pop_o && q_i.cmd.op == OP_ADD;
  assign do_clear  = pop_o && q_i.cmd.op == OP_CLEAR;
  assign do_start  = pop_o && q_i.cmd.op == OP_QUERY;

  // vertices in use and one expansion step
  always_comb begin
    reach = '0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      use_mask[j] = CntW'(j) < n_use_i;
      if (frontier_q[j]) begin
        reach = reach | adj_q[j];
      end
    end
    next_set = reach & use_mask & ~visited_q;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (do_start) begin
        st_d = ST_WALK;
      end
      ST_WALK: if (hit || dead) begin
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (st_q)
      ST_IDLE: begin
        pop_o = !q_i.empty;
        if (!q_i.empty && q_i.cmd.op == OP_MISS) begin
          res_valid_o       = 1'b1;
          res_o.unreachable = 1'b1;
        end
      end
      ST_WALK: begin
        if (hit) begin
          res_valid_o        = 1'b1;
          res_o.hop_distance = level_q;
        end else if (dead) begin
          res_valid_o       = 1'b1;
          res_o.unreachable = 1'b1;
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    frontier_d = frontier_q;
    visited_d  = visited_q;
    level_d    = level_q;
    tgt_d      = tgt_q;
    if (do_start) begin
      frontier_d = MAX_VERTICES'(1) << src_idx;
      visited_d  = MAX_VERTICES'(1) << src_idx;
      level_d    = '0;
      tgt_d      = dst_idx;
    end else if (st_q == ST_WALK && !hit && !dead) begin
      frontier_d = next_set;
      visited_d  = visited_q | next_set;
      level_d    = (level_q == HopMax) ? level_q : level_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      frontier_q <= '0;
      visited_q  <= '0;
      level_q    <= '0;
      tgt_q      <= '0;
    end else begin
      st_q       <= st_d;
      frontier_q <= frontier_d;
      visited_q  <= visited_d;
      level_q    <= level_d;
      tgt_q      <= tgt_d;
    end
  end

  // matrix rows, kept symmetric
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
        adj_q[j] <= '0;
      end
    end else if (do_clear) begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
        adj_q[j] <= '0;
      end
    end else if (do_add) begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
        if (IdxW'(j) == src_idx && IdxW'(j) == dst_idx) begin
          adj_q[j] <= adj_q[j] | (MAX_VERTICES'(1) << dst_idx);
        end else if (IdxW'(j) == src_idx) begin
          adj_q[j] <= adj_q[j] | (MAX_VERTICES'(1) << dst_idx);
        end else if (IdxW'(j) == dst_idx) begin
          adj_q[j] <= adj_q[j] | (MAX_VERTICES'(1) << src_idx);
        end
      end
    end
  end

endmodule

@@ hw/rtl/graph_hop_distance_query.sv @@
// top level: hop distance queries over a small undirected graph
//
//  channel   direction  handshake                  payload
//  command   in         start_i & !busy_o          cmd_i (action, first/second vertex)
//  result    out        result_valid_o, 1 cycle    res_o (hop_distance, unreachable)
//  config    in         cfg_we_i                   cfg_wdata_i (vertex_count)
//
//  add and clear are applied as the engine pops them; a query first loads the
//  walk from the source, then expands one frontier level at a time until the
//  target is hit or the frontier empties; the engine has a single expansion unit
//  out-of-range queries answer as they are popped, with no walk
//  a two-entry command queue lets the front keep taking transactions while a
//  walk runs; busy_o rises only when that queue is full
//  reset clears the matrix, walk registers and queue at once, no sweep
//  results are strobed for one cycle and cannot be held off
`timescale 1ns / 1ps

module graph_hop_distance_query import ghdq_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command transactions
  input  logic               start_i,
  input  ghdq_in_t           cmd_i,
  output logic               busy_o,
  // result transactions
  output logic               result_valid_o,
  output ghdq_out_t          res_o,
  // vertex_count register
  input  logic               cfg_we_i,
  input  logic [VcountW-1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1);

  logic [VcountW-1:0] vcount_q;
  logic [CntW-1:0]    n_use;
  logic               push;
  ghdq_cmd_t          push_cmd;
  ghdq_qstat_t        qstat;
  logic               pop;
  logic               walking;

  // vertex_count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VcountReset;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  // vertices in use: zero reads as one, clamp to the matrix size
  always_comb begin
    if (vcount_q == '0) begin
      n_use = CntW'(1);
    end else if (32'(vcount_q) > MAX_VERTICES) begin
      n_use = CntW'(MAX_VERTICES);
    end else begin
      n_use = CntW'(vcount_q);
    end
  end

  // classify incoming transactions
  ghdq_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .start_i (start_i),
    .busy_i  (busy_o),
    .cmd_i   (cmd_i),
    .n_use_i (n_use),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  // decouple front from engine
  ghdq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .full_o  (busy_o),
    .stat_o  (qstat)
  );

  // matrix and breadth-first walk
  ghdq_engine #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_use_i     (n_use),
    .q_i         (qstat),
    .pop_o       (pop),
    .walking_o   (walking),
    .res_valid_o (result_valid_o),
    .res_o       (res_o)
  );

  // unreachable results always carry distance zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && res_o.unreachable |-> res_o.hop_distance == '0)
    else $error("unreachable result with nonzero distance");

  // the queue only fills through an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && !busy_o))
    else $error("queue filled without an accepted transaction");

  // no command is taken from the queue while a walk runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    walking |-> !pop)
    else $error("queue popped during a walk");

endmodule
